// ----- sv/fixed_partition_fit_allocator_core_defines.svh -----
// Assertion macros for the fixed-partition allocator core.
// No dependencies; the including module must provide clk_i and rst_ni.
`ifndef FIXED_PARTITION_FIT_ALLOCATOR_CORE_DEFINES_SVH
`define FIXED_PARTITION_FIT_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define FPFA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define FPFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/fpfa_pkg.sv -----
// Shared types and constants for the fixed-partition allocator.
// No dependencies.
package fpfa_pkg;

  localparam int unsigned DataW  = 12;
  localparam int unsigned IdW    = 8;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned StatW  = 2;
  localparam int unsigned BlkW   = 5;
  // Cell index and partition count, sized for the largest supported table (64)
  localparam int unsigned CellIdxW = 6;
  localparam int unsigned CellCntW = 7;

  // Command op codes
  localparam logic OpDefine = 1'b0;
  localparam logic OpPlace  = 1'b1;

  // Placement policies
  localparam logic [ModeW-1:0] FitFirst = 2'd0;
  localparam logic [ModeW-1:0] FitBest  = 2'd1;
  localparam logic [ModeW-1:0] FitWorst = 2'd2;

  // Result status codes
  localparam logic [StatW-1:0] StOk    = 2'd0;
  localparam logic [StatW-1:0] StNoMem = 2'd1;
  localparam logic [StatW-1:0] StNoFit = 2'd2;
  localparam logic [StatW-1:0] StFull  = 2'd3;

  // Register indexes
  localparam logic [1:0] CfgFitMode  = 2'd0;
  localparam logic [1:0] CfgTotalMem = 2'd1;
  localparam logic [1:0] CfgOsRsvd   = 2'd2;

  // Search token handed from cell to cell
  typedef struct packed {
    logic                valid;
    logic [ModeW-1:0]    mode;
    logic [DataW-1:0]    req;
    logic                found;
    logic [CellIdxW-1:0] idx;
    logic [DataW-1:0]    gap;
    logic [DataW-1:0]    base;
    logic [DataW-1:0]    psize;
  } probe_t;

  // Broadcast entry update: partition define or job commit
  typedef struct packed {
    logic                def_we;
    logic                commit_we;
    logic [CellIdxW-1:0] idx;
    logic [DataW-1:0]    size;
    logic [DataW-1:0]    base;
    logic [IdW-1:0]      owner;
    logic [DataW-1:0]    leftover;
  } upd_t;

endpackage

// ----- sv/fpfa_cell.sv -----
// One partition-table entry plus one stage of the search chain.
// Depends on fpfa_pkg.
module fpfa_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [fpfa_pkg::CellCntW-1:0] count_i,
  input  fpfa_pkg::upd_t            upd_i,
  input  fpfa_pkg::probe_t          probe_i,
  output fpfa_pkg::probe_t          probe_o
);

  logic [fpfa_pkg::DataW-1:0] size_q, base_q;
  logic                       busy_q;
  logic [fpfa_pkg::IdW-1:0]   owner_q;
  logic [fpfa_pkg::DataW-1:0] left_q;
  fpfa_pkg::probe_t           probe_q, probe_d;

  logic                       hit, fits, better;
  logic [fpfa_pkg::DataW-1:0] gap;

  assign hit  = (upd_i.idx == fpfa_pkg::CellIdxW'(Idx));
  assign fits = (fpfa_pkg::CellCntW'(Idx) < count_i) && !busy_q && (size_q >= probe_i.req);
  assign gap  = size_q - probe_i.req;

  always_comb begin
    unique case (probe_i.mode)
      fpfa_pkg::FitFirst: better = !probe_i.found;
      fpfa_pkg::FitBest:  better = !probe_i.found || (gap < probe_i.gap);
      fpfa_pkg::FitWorst: better = !probe_i.found || (gap > probe_i.gap);
      default:            better = 1'b0;
    endcase
  end

  always_comb begin
    probe_d = probe_i;
    if (fits && better) begin
      probe_d.found = 1'b1;
      probe_d.idx   = fpfa_pkg::CellIdxW'(Idx);
      probe_d.gap   = gap;
      probe_d.base  = base_q;
      probe_d.psize = size_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q <= '0;
    end else begin
      probe_q <= probe_d;
    end
  end

  // Size and base are only read once defined (guarded by count_i)
  always_ff @(posedge clk_i) begin
    if (upd_i.def_we && hit) begin
      size_q <= upd_i.size;
      base_q <= upd_i.base;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      owner_q <= '0;
      left_q  <= '0;
    end else if (hit && (upd_i.def_we || upd_i.commit_we)) begin
      busy_q  <= upd_i.commit_we;
      owner_q <= upd_i.owner;
      left_q  <= upd_i.leftover;
    end
  end

  assign probe_o = probe_q;

endmodule

// ----- sv/fixed_partition_fit_allocator_core.sv -----
// Fixed-partition memory allocator, top level.
// Depends on fpfa_pkg, fpfa_cell and fixed_partition_fit_allocator_core_defines.svh.
//
// A beat is taken when start is high and busy is low. Op 0 defines the next
// partition right after the OS area and the earlier partitions; its result
// strobes on done_o in the cycle after the beat. Op 1 places a job: a search
// token walks the row of MAX_PARTITIONS cells, one cell per cycle, each cell
// holding one partition entry and applying first, best or worst fit; once the
// token leaves the last cell, the result is registered and strobes, and the
// chosen entry is marked busy at the same edge. busy stays high for the whole
// walk, so no new beat is taken until the job result is out; a define beat
// does not raise busy. done_o is high for exactly one cycle per beat and the
// receiver has no way to stall it; capture the result fields in that cycle.
// The user must write registers through cfg_we_i/cfg_idx_i/cfg_data_i only
// while no job is in flight; the block itself does not enforce this. Unknown
// indexes are ignored.
`include "fixed_partition_fit_allocator_core_defines.svh"

module fixed_partition_fit_allocator_core #(
  parameter int unsigned MAX_PARTITIONS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  logic [0:0]                    op_i,
  input  logic [fpfa_pkg::DataW-1:0]    req_size_i,
  input  logic [fpfa_pkg::IdW-1:0]      job_id_i,
  // result strobe
  output logic                          done_o,
  output logic [fpfa_pkg::StatW-1:0]    status_o,
  output logic [fpfa_pkg::BlkW-1:0]     block_index_o,
  output logic [fpfa_pkg::DataW-1:0]    start_address_o,
  output logic [fpfa_pkg::DataW-1:0]    end_address_o,
  output logic [fpfa_pkg::DataW-1:0]    leftover_o,
  // register write port
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [fpfa_pkg::DataW-1:0]    cfg_data_i
);

  localparam int unsigned CntW = $clog2(MAX_PARTITIONS + 1);

  // Configuration registers
  logic [fpfa_pkg::ModeW-1:0] fit_mode_q;
  logic [fpfa_pkg::DataW-1:0] total_mem_q, os_rsvd_q;

  // Table bookkeeping
  logic [CntW-1:0]            part_count_q;
  logic [fpfa_pkg::DataW-1:0] alloc_sum_q;
  logic                       busy_q;
  logic [fpfa_pkg::IdW-1:0]   job_q;

  // Result registers
  logic                       done_q;
  logic [fpfa_pkg::StatW-1:0] status_q;
  logic [fpfa_pkg::BlkW-1:0]  blk_q;
  logic [fpfa_pkg::DataW-1:0] saddr_q, eaddr_q, left_q;

  logic                       accept, acc_def, acc_job;
  fpfa_pkg::probe_t           chain [MAX_PARTITIONS+1];
  fpfa_pkg::probe_t           tail;
  fpfa_pkg::upd_t             upd;

  // Define-path checks
  logic [fpfa_pkg::DataW:0]   used;
  logic [fpfa_pkg::DataW:0]   remain;
  logic                       size_bad, table_full;

  assign accept  = start && !busy_q;
  assign acc_def = accept && (op_i == fpfa_pkg::OpDefine);
  assign acc_job = accept && (op_i == fpfa_pkg::OpPlace);

  assign used       = {1'b0, os_rsvd_q} + {1'b0, alloc_sum_q};
  assign remain     = ({1'b0, total_mem_q} > used) ? ({1'b0, total_mem_q} - used) : '0;
  assign size_bad   = (req_size_i == '0) || ({1'b0, req_size_i} > remain);
  assign table_full = (part_count_q == CntW'(MAX_PARTITIONS));

  // Search token enters cell 0 on a job beat
  always_comb begin
    chain[0]       = '0;
    chain[0].valid = acc_job;
    chain[0].mode  = fit_mode_q;
    chain[0].req   = req_size_i;
  end

  for (genvar g = 0; g < MAX_PARTITIONS; g++) begin : g_cell
    fpfa_cell #(
      .Idx(g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .count_i (fpfa_pkg::CellCntW'(part_count_q)),
      .upd_i   (upd),
      .probe_i (chain[g]),
      .probe_o (chain[g+1])
    );
  end

  assign tail = chain[MAX_PARTITIONS];

  // Entry update broadcast: define writes the next free slot, commit marks the winner
  always_comb begin
    upd           = '0;
    upd.def_we    = acc_def && !size_bad && !table_full;
    upd.commit_we = tail.valid && tail.found;
    upd.size      = req_size_i;
    upd.base      = used[fpfa_pkg::DataW-1:0];
    if (tail.valid) begin
      upd.idx      = tail.idx;
      upd.owner    = job_q;
      upd.leftover = tail.gap;
    end else begin
      upd.idx      = fpfa_pkg::CellIdxW'(part_count_q);
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_mode_q  <= fpfa_pkg::FitFirst;
      total_mem_q <= 12'd200;
      os_rsvd_q   <= 12'd20;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fpfa_pkg::CfgFitMode:  fit_mode_q  <= cfg_data_i[fpfa_pkg::ModeW-1:0];
        fpfa_pkg::CfgTotalMem: total_mem_q <= cfg_data_i;
        fpfa_pkg::CfgOsRsvd:   os_rsvd_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Control: count, allocated sum, busy, job id capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_count_q <= '0;
      alloc_sum_q  <= '0;
      busy_q       <= 1'b0;
      job_q        <= '0;
    end else begin
      if (upd.def_we) begin
        part_count_q <= part_count_q + CntW'(1);
        alloc_sum_q  <= alloc_sum_q + req_size_i;
      end
      if (acc_job) begin
        busy_q <= 1'b1;
        job_q  <= job_id_i;
      end else if (tail.valid) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= acc_def || tail.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tail.valid) begin
      if (tail.found) begin
        status_q <= fpfa_pkg::StOk;
        blk_q    <= fpfa_pkg::BlkW'(32'(tail.idx) + 32'd1);
        saddr_q  <= tail.base;
        eaddr_q  <= tail.base + tail.psize - 12'd1;
        left_q   <= tail.gap;
      end else begin
        status_q <= fpfa_pkg::StNoFit;
        blk_q    <= '0;
        saddr_q  <= '0;
        eaddr_q  <= '0;
        left_q   <= '0;
      end
    end else if (acc_def) begin
      left_q <= '0;
      priority if (size_bad) begin
        status_q <= fpfa_pkg::StNoMem;
        blk_q    <= '0;
        saddr_q  <= '0;
        eaddr_q  <= '0;
      end else if (table_full) begin
        status_q <= fpfa_pkg::StFull;
        blk_q    <= '0;
        saddr_q  <= '0;
        eaddr_q  <= '0;
      end else begin
        status_q <= fpfa_pkg::StOk;
        blk_q    <= fpfa_pkg::BlkW'(32'(part_count_q) + 32'd1);
        saddr_q  <= used[fpfa_pkg::DataW-1:0];
        eaddr_q  <= used[fpfa_pkg::DataW-1:0] + req_size_i - 12'd1;
      end
    end
  end

  assign busy            = busy_q;
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign block_index_o   = blk_q;
  assign start_address_o = saddr_q;
  assign end_address_o   = eaddr_q;
  assign leftover_o      = left_q;

  // Checks
  `FPFA_ASSERT_IMPL(a_no_done_while_busy, done_q, !busy_q, "result beat while job in flight")
  `FPFA_ASSERT_NEXT(a_job_sets_busy, acc_job, busy_q, "job beat did not raise busy")
  `FPFA_ASSERT_NEXT(a_tail_gives_done, tail.valid, done_q && !busy_q, "search end gave no result")
  `FPFA_ASSERT_IMPL(a_count_bound, 1'b1, part_count_q <= CntW'(MAX_PARTITIONS), "count overflow")

endmodule
